// ===== src/urc_pkg.sv =====
// Shared types, codes and constants of the ultrasonic ranging controller.
package urc_pkg;

   // Item kinds on the request channel
   localparam logic FUNC_CMD  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Units codes taken from the first byte of a range command
   localparam logic [1:0] MODE_INCH = 2'd0;
   localparam logic [1:0] MODE_CM   = 2'd1;
   localparam logic [1:0] MODE_US   = 2'd2;

   // Address change key and reserved addresses
   localparam logic [7:0] ADDR_KEY0      = 8'hA0;
   localparam logic [7:0] ADDR_KEY1      = 8'hAA;
   localparam logic [7:0] ADDR_KEY2      = 8'hA5;
   localparam logic [7:0] ADDR_RESERVED0 = 8'h00;
   localparam logic [7:0] ADDR_RESERVED1 = 8'h7F;
   localparam logic [2:0] ADDR_CMD_LEN   = 3'd4;
   localparam logic [7:0] RANGE_FAIL     = 8'hFF;

   // Register indexes of the configuration port
   localparam int unsigned CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CSR_TIMEOUT = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_TICK    = 1'b1;
   localparam int unsigned CsrDataW = 16;

   // Register reset values
   localparam logic [15:0] TIMEOUT_RESET = 16'd29000;
   localparam logic [7:0]  TICK_RESET    = 8'd10;

   // Reciprocal constants: q = (d * M) >> S is exact for every 16-bit d
   localparam logic [16:0] DIV148_MULT  = 17'd113360;
   localparam int unsigned DIV148_SHIFT = 24;
   localparam logic [16:0] DIV58_MULT   = 17'd72316;
   localparam int unsigned DIV58_SHIFT  = 22;

   typedef struct packed {
      logic       func;
      logic [2:0] cmd_len;
      logic [7:0] cmd_byte0;
      logic [7:0] cmd_byte1;
      logic [7:0] cmd_byte2;
      logic [7:0] cmd_byte3;
      logic       echo;
   } req_type;

   typedef struct packed {
      logic       trigger;
      logic       busy_res;
      logic       range_valid;
      logic [7:0] range_high;
      logic [7:0] range_low;
      logic       address_valid;
      logic [7:0] new_address;
   } rsp_type;

   typedef struct packed {
      logic [15:0] timeout_us;
      logic [7:0]  tick_us;
   } cfg_type;

endpackage

// ===== src/urc_range_conv.sv =====
// Converts an echo time in microseconds to inches, centimetres or microseconds.
module urc_range_conv import urc_pkg::*; (
   input  logic [15:0] elapsed_us,
   input  logic [1:0]  units_mode,
   output logic [15:0] range_value
);

   logic [16:0] mult;
   logic [32:0] prod;
   logic [32:0] shifted;

   always_comb begin
      mult    = (units_mode == MODE_CM) ? DIV58_MULT : DIV148_MULT;
      prod    = 33'(elapsed_us) * 33'(mult);
      shifted = (units_mode == MODE_CM) ? (prod >> DIV58_SHIFT) : (prod >> DIV148_SHIFT);
      case (units_mode)
         MODE_INCH, MODE_CM: range_value = shifted[15:0];
         default:            range_value = elapsed_us;
      endcase
   end

endmodule

// ===== src/urc_fsm.sv =====
// Ranging sequencer: phase, echo timer and units, and the result of each item.
module urc_fsm import urc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG,
      PH_RISE,
      PH_MEAS
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] range_value;
   logic [16:0] sum;
   logic        addr_ok;

   urc_range_conv u_conv (
      .elapsed_us (elapsed_ff),
      .units_mode (mode_ff),
      .range_value(range_value)
   );

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      mode_in    = mode_ff;
      result     = '0;
      sum        = 17'(elapsed_ff) + 17'(cfg.tick_us);
      addr_ok    = (item.cmd_len >= ADDR_CMD_LEN) && (item.cmd_byte0 == ADDR_KEY0) &&
                   (item.cmd_byte1 == ADDR_KEY1) && (item.cmd_byte2 == ADDR_KEY2) &&
                   (item.cmd_byte3 != ADDR_RESERVED0) && (item.cmd_byte3 != ADDR_RESERVED1);

      if (item.func == FUNC_CMD) begin
         if (phase_ff == PH_IDLE && item.cmd_len != 3'd0) begin
            if (item.cmd_byte0 <= 8'(MODE_US)) begin
               if (item.echo) begin
                  // Echo already high: the pulse would be meaningless
                  result.range_valid = 1'b1;
                  result.range_high  = RANGE_FAIL;
                  result.range_low   = RANGE_FAIL;
               end else begin
                  mode_in    = item.cmd_byte0[1:0];
                  elapsed_in = '0;
                  phase_in   = PH_TRIG;
               end
            end else if (addr_ok) begin
               result.address_valid = 1'b1;
               result.new_address   = item.cmd_byte3;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_TRIG: phase_in = PH_RISE;
            PH_RISE: begin
               if (item.echo) begin
                  elapsed_in = '0;
                  phase_in   = PH_MEAS;
               end
            end
            PH_MEAS: begin
               if (!item.echo) begin
                  result.range_valid = 1'b1;
                  result.range_high  = {1'b0, range_value[14:8]};
                  result.range_low   = range_value[7:0];
                  phase_in           = PH_IDLE;
               end else if (elapsed_ff > cfg.timeout_us) begin
                  result.range_valid = 1'b1;
                  result.range_high  = RANGE_FAIL;
                  result.range_low   = RANGE_FAIL;
                  phase_in           = PH_IDLE;
               end else begin
                  elapsed_in = sum[16] ? 16'hFFFF : sum[15:0];
               end
            end
            default: ;
         endcase
      end

      result.trigger  = (phase_in == PH_TRIG);
      result.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
         mode_ff    <= MODE_INCH;
      end else if (step) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         mode_ff    <= mode_in;
      end
   end

endmodule

// ===== src/ultrasonic_ranging_controller_top.sv =====
// Top level of the ultrasonic ranging controller: channels, registers and assertions.
//
// The controller takes one beat per clock cycle on the request channel, either a bus command
// (func 0) or a timer tick carrying a sample of the echo pin (func 1), and returns exactly one
// response beat for every request beat, in order. A request beat is first captured in an
// input register; the sequencer then evaluates it against the ranging state and the response
// is captured in the output register. While the response channel does not stall, the
// sustained rate is one beat per cycle; it is set by the single sequencer update between the
// two registers, which also carries the reciprocal multiply that converts the echo time to
// inches or centimetres. Back-pressure on the response channel holds the output register and,
// once the input register is also full, stalls the request channel. The configuration port
// (timeout_us at index 0, tick_us at index 1, taken from the low bits of the write data) is
// always ready and should only be written while no beat is in flight.
module ultrasonic_ranging_controller_top import urc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   cfg_type cfg_ff;
   logic    advance;
   logic    step;
   rsp_type result;

   // The pipeline moves whenever the output register is empty or being drained.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = advance && in_valid_ff;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   urc_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_data_ff),
      .cfg   (cfg_ff),
      .result(result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= result;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_us <= TIMEOUT_RESET;
         cfg_ff.tick_us    <= TICK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMEOUT: cfg_ff.timeout_us <= csr_wdata[15:0];
            CSR_TICK:    cfg_ff.tick_us    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   // A beat that ends in a range report always leaves the sequencer idle.
   a_range_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.range_valid |-> !rsp_data.busy_res)
      else $error("range reported while still busy");

   // The trigger is only driven during a ranging operation.
   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.trigger |-> rsp_data.busy_res && !rsp_data.range_valid)
      else $error("trigger driven outside a ranging operation");

   // A range report and an address change never share a beat.
   a_one_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.range_valid && rsp_data.address_valid))
      else $error("range and address reported together");

   // The request side only stalls when a beat waits in the input register.
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled without a full pipeline");
`endif

endmodule

// ===== bench/tb_ultrasonic_ranging_controller_top.sv =====
// Self-checking testbench for the ultrasonic ranging controller top level.
`timescale 1ns / 100ps

module tb_ultrasonic_ranging_controller_top;
   import urc_pkg::*;

   // Ranging sequence as the predictor tracks it: idle, trigger pulse, waiting for the echo to
   // rise, and timing the echo pulse.
   typedef enum logic [1:0] {
      RANGE_IDLE,
      RANGE_TRIGGER,
      RANGE_AWAIT_ECHO,
      RANGE_TIMING
   } range_phase_e;

   // Speed-of-sound divisors that turn echo time into inches and centimetres.
   localparam int unsigned INCH_DIVISOR = 148;
   localparam int unsigned CM_DIVISOR   = 58;
   // Cycles in which no channel moves a beat before the run is declared hung. The longest
   // legitimate quiet stretch is the deliberate receiver hold-off, set by HOLD_CYCLES.
   localparam int unsigned QUIET_LIMIT  = 4000;
   localparam int unsigned IDLE_PCT     = 6;
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned PHASE_BEATS  = 170;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = CSR_TIMEOUT;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // Predictor state, a private copy of what the controller should hold.
   range_phase_e range_phase;
   logic [15:0]  echo_time_us;
   logic [1:0]   units_code;
   logic [15:0]  timeout_limit_us;
   logic [7:0]   tick_step_us;

   rsp_type     expected_rsp_q[$];
   int unsigned mismatch_count       = 0;
   int unsigned beats_sent           = 0;
   int unsigned sender_idle_pct      = IDLE_PCT;
   int unsigned receiver_idle_pct    = IDLE_PCT;
   int unsigned receiver_hold_cycles = 0;
   int unsigned quiet_cycles         = 0;

   ultrasonic_ranging_controller_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Works out the response beat that one accepted request beat must produce, and advances
   // the predictor state. Every request beat yields exactly one response beat.
   function automatic rsp_type predict_response(input req_type beat);
      rsp_type     answer;
      logic [16:0] summed_us;
      logic [15:0] distance;
      answer = '0;
      if (beat.func == FUNC_CMD) begin
         // Commands only count while idle and with at least one byte received.
         if (range_phase == RANGE_IDLE && beat.cmd_len != 3'd0) begin
            if (beat.cmd_byte0 <= {6'd0, MODE_US}) begin
               if (beat.echo) begin
                  // The echo line is already high, so nothing sensible can be timed.
                  answer.range_valid = 1'b1;
                  answer.range_high  = RANGE_FAIL;
                  answer.range_low   = RANGE_FAIL;
               end else begin
                  units_code   = beat.cmd_byte0[1:0];
                  echo_time_us = '0;
                  range_phase  = RANGE_TRIGGER;
               end
            end else if (beat.cmd_len >= ADDR_CMD_LEN && beat.cmd_byte0 == ADDR_KEY0 &&
                         beat.cmd_byte1 == ADDR_KEY1 && beat.cmd_byte2 == ADDR_KEY2) begin
               if (beat.cmd_byte3 != ADDR_RESERVED0 && beat.cmd_byte3 != ADDR_RESERVED1) begin
                  answer.address_valid = 1'b1;
                  answer.new_address   = beat.cmd_byte3;
               end
            end
         end
      end else begin
         case (range_phase)
            RANGE_TRIGGER: range_phase = RANGE_AWAIT_ECHO;
            RANGE_AWAIT_ECHO: begin
               if (beat.echo) begin
                  echo_time_us = '0;
                  range_phase  = RANGE_TIMING;
               end
            end
            RANGE_TIMING: begin
               if (!beat.echo) begin
                  case (units_code)
                     MODE_INCH: distance = 16'(echo_time_us / INCH_DIVISOR);
                     MODE_CM:   distance = 16'(echo_time_us / CM_DIVISOR);
                     default:   distance = echo_time_us;
                  endcase
                  answer.range_valid = 1'b1;
                  answer.range_high  = {1'b0, distance[14:8]};
                  answer.range_low   = distance[7:0];
                  range_phase        = RANGE_IDLE;
               end else if (echo_time_us > timeout_limit_us) begin
                  answer.range_valid = 1'b1;
                  answer.range_high  = RANGE_FAIL;
                  answer.range_low   = RANGE_FAIL;
                  range_phase        = RANGE_IDLE;
               end else begin
                  summed_us    = 17'(echo_time_us) + 17'(tick_step_us);
                  echo_time_us = summed_us[16] ? 16'hFFFF : summed_us[15:0];
               end
            end
            default: ;
         endcase
      end
      answer.trigger  = (range_phase == RANGE_TRIGGER);
      answer.busy_res = (range_phase != RANGE_IDLE);
      return answer;
   endfunction

   function automatic req_type command_beat(input logic [2:0] len, input logic [7:0] b0,
                                            input logic [7:0] b1, input logic [7:0] b2,
                                            input logic [7:0] b3, input logic echo_level);
      req_type beat;
      beat.func      = FUNC_CMD;
      beat.cmd_len   = len;
      beat.cmd_byte0 = b0;
      beat.cmd_byte1 = b1;
      beat.cmd_byte2 = b2;
      beat.cmd_byte3 = b3;
      beat.echo      = echo_level;
      return beat;
   endfunction

   // A tick beat with random command fields, which the controller must disregard.
   function automatic req_type tick_beat(input logic echo_level);
      req_type beat;
      beat = command_beat(3'($urandom_range(7)), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), echo_level);
      beat.func = FUNC_TICK;
      return beat;
   endfunction

   function automatic req_type random_beat();
      req_type beat;
      beat = command_beat(3'($urandom_range(7)), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 1'($urandom_range(1)));
      beat.func = 1'($urandom_range(1));
      return beat;
   endfunction

   // Offers one request beat, with the occasional random gap in front of it, and records the
   // expected response at the edge where the beat is taken. The valid is left high on return
   // so that back-to-back beats follow with no gap.
   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp_q.push_back(predict_response(beat));
      beats_sent++;
   endtask

   // Lowers the request valid and waits until every expected response beat has arrived.
   // Every request beat has its response, so nothing is left in flight afterwards.
   task automatic settle_outstanding();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Writes both registers back to back once the controller is quiet. The tick register
   // only uses the low byte, so the upper byte carries random junk.
   task automatic apply_settings(input logic [15:0] timeout_us, input logic [7:0] tick_us);
      settle_outstanding();
      csr_valid <= 1'b1;
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= timeout_us;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      timeout_limit_us = timeout_us;
      csr_index <= CSR_TICK;
      csr_wdata <= {8'($urandom), tick_us};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tick_step_us = tick_us;
      csr_valid <= 1'b0;
   endtask

   // One complete measurement: range command, an optional command while busy, trigger tick, ticks
   // with the echo low, the tick where it rises, ticks with it high, and the tick where it falls.
   task automatic run_measurement(input logic [1:0] mode, input int unsigned settle_ticks,
                                  input int unsigned timed_ticks, input bit busy_command);
      send_beat(command_beat(3'($urandom_range(1, 7)), {6'd0, mode}, 8'($urandom),
                             8'($urandom), 8'($urandom), 1'b0));
      if (busy_command) send_beat(command_beat(3'($urandom_range(1, 7)),
                                               8'($urandom_range(3)), 8'($urandom),
                                               8'($urandom), 8'($urandom), 1'b0));
      // The echo sample on the trigger tick must be ignored, so it is random.
      send_beat(tick_beat(1'($urandom_range(1))));
      repeat (settle_ticks) send_beat(tick_beat(1'b0));
      send_beat(tick_beat(1'b1));
      repeat (timed_ticks) send_beat(tick_beat(1'b1));
      send_beat(tick_beat(1'b0));
   endtask

   // Checks one response beat against the oldest expectation, field by field.
   task automatic check_response(input rsp_type seen);
      rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         $error("response beat %h arrived with nothing expected", seen);
         mismatch_count++;
      end else begin
         want = expected_rsp_q.pop_front();
         if (seen.trigger !== want.trigger) begin
            $error("trigger: expected %0h, got %0h", want.trigger, seen.trigger);
            mismatch_count++;
         end
         if (seen.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0h, got %0h", want.busy_res, seen.busy_res);
            mismatch_count++;
         end
         if (seen.range_valid !== want.range_valid) begin
            $error("range_valid: expected %0h, got %0h", want.range_valid, seen.range_valid);
            mismatch_count++;
         end
         if (seen.range_high !== want.range_high) begin
            $error("range_high: expected %0h, got %0h", want.range_high, seen.range_high);
            mismatch_count++;
         end
         if (seen.range_low !== want.range_low) begin
            $error("range_low: expected %0h, got %0h", want.range_low, seen.range_low);
            mismatch_count++;
         end
         if (seen.address_valid !== want.address_valid) begin
            $error("address_valid: expected %0h, got %0h", want.address_valid,
                   seen.address_valid);
            mismatch_count++;
         end
         if (seen.new_address !== want.new_address) begin
            $error("new_address: expected %0h, got %0h", want.new_address, seen.new_address);
            mismatch_count++;
         end
      end
   endtask

   // Response side: checks each beat taken at an edge, then decides the stall for the next
   // edge. A hold-off request from a test is counted down here, in this process alone, and
   // keeps the stall high throughout so that the controller fills and stalls its input.
   initial begin : response_side
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_response(rsp_data);
         if (receiver_hold_cycles != 0) begin
            hold_left            = receiver_hold_cycles;
            receiver_hold_cycles = 0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   // Watchdog: any beat moving on any channel proves progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // A measurement with the register values left by reset: 15 ticks of 10 us give 150 us,
   // which is one inch. A command sent mid-measurement must be ignored.
   task automatic test_reset_configuration();
      run_measurement(MODE_INCH, 1, 15, 1'b1);
   endtask

   // Command decoding while idle: empty commands, lost echo, the address-change key with
   // good, short, over-long, reserved and corrupted forms, unknown first bytes and idle ticks.
   task automatic test_command_decoding();
      send_beat(command_beat(3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      send_beat(command_beat(3'd0, ADDR_KEY0, ADDR_KEY1, ADDR_KEY2, 8'h42, 1'b1));
      send_beat(tick_beat(1'b1));
      send_beat(command_beat(3'd1, {6'd0, MODE_US}, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_beat(command_beat(3'd4, ADDR_KEY0, ADDR_KEY1, ADDR_KEY2, 8'h42, 1'b0));
      send_beat(command_beat(3'd7, ADDR_KEY0, ADDR_KEY1, ADDR_KEY2, 8'hFF, 1'b1));
      send_beat(command_beat(3'd3, ADDR_KEY0, ADDR_KEY1, ADDR_KEY2, 8'h42, 1'b0));
      send_beat(command_beat(3'd4, ADDR_KEY0, ADDR_KEY1, ADDR_KEY2, ADDR_RESERVED0, 1'b0));
      send_beat(command_beat(3'd5, ADDR_KEY0, ADDR_KEY1, ADDR_KEY2, ADDR_RESERVED1, 1'b0));
      send_beat(command_beat(3'd4, ADDR_KEY0, ADDR_KEY1, 8'hA4, 8'h42, 1'b0));
      send_beat(command_beat(3'd4, 8'h03, ADDR_KEY1, ADDR_KEY2, 8'h42, 1'b0));
      send_beat(command_beat(3'd6, 8'hFF, 8'h00, 8'h00, 8'h01, 1'b1));
   endtask

   // Register extremes: a zero timeout with the longest tick, where the second timed tick
   // already times out; then the largest timeout, where the echo time saturates at 0xFFFF
   // and the microsecond report loses bit 15; finally the shortest tick.
   task automatic test_register_extremes();
      apply_settings(16'd0, 8'd255);
      run_measurement(MODE_US, 1, 1, 1'b0);
      run_measurement(MODE_US, 0, 2, 1'b0);
      run_measurement(MODE_CM, 2, 0, 1'b0);
      apply_settings(16'hFFFF, 8'd255);
      run_measurement(MODE_US, 1, 260, 1'b0);
      run_measurement(MODE_INCH, 0, 100, 1'b0);
      run_measurement(MODE_CM, 1, 100, 1'b1);
      apply_settings(16'hFFFF, 8'd1);
      run_measurement(MODE_US, 2, 30, 1'b0);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering beats with no
   // gaps, so the output and input registers fill and the request channel stalls.
   task automatic test_response_backpressure();
      apply_settings(16'd500, 8'd25);
      sender_idle_pct      = 0;
      receiver_hold_cycles = HOLD_CYCLES;
      run_measurement(MODE_INCH, 1, 8, 1'b0);
      run_measurement(MODE_CM, 0, 25, 1'b1);
      run_measurement(MODE_US, 2, 8, 1'b0);
      settle_outstanding();
      sender_idle_pct = IDLE_PCT;
   endtask

   // Random traffic over several register settings. Most of it is well-formed measurements
   // with random timing, so that timeouts and every unit are reached; the rest is lost-echo
   // commands, address changes and entirely random beats. One setting runs with no idling on
   // either side.
   task automatic test_random_ranging();
      int unsigned phase_start;
      int unsigned pick;
      int unsigned max_timed;
      logic [7:0]  tick_us;
      logic [15:0] timeout_us;
      logic [7:0]  key2;
      logic [7:0]  new_addr;
      for (int setting = 0; setting < 6; setting++) begin
         case (setting)
            0: tick_us = 8'd1;
            1: tick_us = 8'd255;
            5: tick_us = TICK_RESET;
            default: tick_us = 8'($urandom_range(2, 254));
         endcase
         case (setting)
            2: timeout_us = 16'd0;
            4: timeout_us = 16'hFFFF;
            5: timeout_us = TIMEOUT_RESET;
            default: timeout_us = 16'($urandom_range(int'(tick_us) * 40));
         endcase
         apply_settings(timeout_us, tick_us);
         sender_idle_pct   = (setting == 3) ? 0 : IDLE_PCT;
         receiver_idle_pct = (setting == 3) ? 0 : IDLE_PCT;
         max_timed = int'(timeout_us) / int'(tick_us) + 3;
         if (max_timed > 60) max_timed = 60;
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BEATS) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               run_measurement(2'($urandom_range(2)), $urandom_range(3),
                               $urandom_range(max_timed), $urandom_range(99) < 15);
            end else if (pick < 70) begin
               send_beat(command_beat(3'($urandom_range(1, 7)), 8'($urandom_range(2)),
                                      8'($urandom), 8'($urandom), 8'($urandom), 1'b1));
            end else if (pick < 82) begin
               key2     = ($urandom_range(4) == 0) ? 8'($urandom) : ADDR_KEY2;
               new_addr = 8'($urandom);
               if ($urandom_range(3) == 0) new_addr = $urandom_range(1) ? ADDR_RESERVED1
                                                                          : ADDR_RESERVED0;
               send_beat(command_beat(3'($urandom_range(3, 7)), ADDR_KEY0, ADDR_KEY1, key2,
                                      new_addr, 1'($urandom_range(1))));
            end else begin
               send_beat(random_beat());
            end
         end
      end
      sender_idle_pct   = IDLE_PCT;
      receiver_idle_pct = IDLE_PCT;
   endtask

   initial begin
      // Predictor state after reset.
      range_phase      = RANGE_IDLE;
      echo_time_us     = '0;
      units_code       = MODE_INCH;
      timeout_limit_us = TIMEOUT_RESET;
      tick_step_us     = TICK_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_configuration();
      test_command_decoding();
      test_register_extremes();
      test_response_backpressure();
      test_random_ranging();
      settle_outstanding();
      // Run on so that any spurious extra response beat would still be caught.
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
